>>> rtl/phsc_pkg.sv
// Shared types, codes and sizes for the packet header statistics counter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none
package phsc_pkg;

  localparam int COUNTER_SLOTS   = 32;
  localparam int GEN_AW          = $clog2(COUNTER_SLOTS);
  localparam int PORT_ENTRIES    = 65536;
  localparam int PORT_AW         = 16;
  localparam int MAX_EXT_HEADERS = 8;
  localparam int NUM_EVENTS      = 14;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  // General counter slots.
  localparam int C_PKT   = 0;
  localparam int C_BYTES = 1;
  localparam int C_IP    = 2;
  localparam int C_IP6   = 3;
  localparam int C_TCP   = 4;
  localparam int C_UDP   = 5;
  localparam int C_ICMP  = 6;
  localparam int C_ICMP6 = 7;
  localparam int C_ARP   = 8;
  localparam int C_ACK   = 9;
  localparam int C_SYN   = 10;
  localparam int C_FIN   = 11;
  localparam int C_RST   = 12;
  localparam int C_FRAG  = 13;

  // Input commands.
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_RD_GEN   = 2'd1;
  localparam logic [1:0] CMD_RD_PORT  = 2'd2;

  // Result kinds.
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_COUNT   = 1'b1;

  // Ether types, IP protocol numbers and field masks.
  localparam logic [15:0] ETH_IP4       = 16'h0800;
  localparam logic [15:0] ETH_IP6       = 16'h86DD;
  localparam logic [15:0] ETH_ARP       = 16'h0806;
  localparam logic [15:0] FRAG_MF_MASK  = 16'h2000;
  localparam logic [15:0] FRAG_OFF_MASK = 16'h1fff;
  localparam logic [15:0] FRAG6_MASK    = 16'hfff9;
  localparam logic [7:0]  PROTO_HOPOPT  = 8'd0;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ROUTE   = 8'd43;
  localparam logic [7:0]  PROTO_FRAG    = 8'd44;
  localparam logic [7:0]  PROTO_ESP     = 8'd50;
  localparam logic [7:0]  PROTO_AH      = 8'd51;
  localparam logic [7:0]  PROTO_ICMP6   = 8'd58;
  localparam logic [7:0]  PROTO_DSTOPT  = 8'd60;

  typedef enum logic [3:0] {
    PH_ETH, PH_IP4, PH_IP6, PH_AH, PH_OPT, PH_FRAG, PH_TCP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    OP_BYTE, OP_RD_GEN, OP_RD_PORT
  } op_kind_t;

  // One classified item handed from the parser to the counter engine.
  typedef struct packed {
    op_kind_t              kind;
    logic [NUM_EVENTS-1:0] bump;
    logic                  port_inc;
    logic [PORT_AW-1:0]    index;
    logic                  emit;
    logic                  verdict;
  } op_t;

endpackage
`default_nettype wire

>>> rtl/phsc_front.sv
// Byte-wise header parser: classifies each item into a counter operation.
// Depends on phsc_pkg.
`default_nettype none
module phsc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [1:0]     command,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  input  wire logic [15:0]    read_index,
  output logic                push,
  output phsc_pkg::op_t       op
);

  typedef struct packed {
    phsc_pkg::phase_t ph;
    logic [15:0]      len;
    logic [3:0]       ext;
  } next_hdr_t;

  phsc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] hend_r, hend_nxt;
  logic [7:0]  nproto_r, nproto_nxt;
  logic [3:0]  ext_r, ext_nxt;
  logic [15:0] fsh_r, fsh_nxt;

  logic [phsc_pkg::NUM_EVENTS-1:0] bump;
  logic        port_inc;
  logic        ent, adv_pos;
  next_hdr_t   ent_h;
  logic [15:0] shifted, hend_eff;
  logic [16:0] pos_p1;
  logic [5:0]  ihl4;

  // Decision taken after an IP or extension header completes.
  function automatic next_hdr_t after_ip(input logic [7:0] p, input logic [3:0] e);
    next_hdr_t r;
    r.ph  = phsc_pkg::PH_DONE;
    r.len = 16'd0;
    r.ext = e;
    if (e < 4'(phsc_pkg::MAX_EXT_HEADERS) && (p == phsc_pkg::PROTO_HOPOPT ||
        p == phsc_pkg::PROTO_ROUTE || p == phsc_pkg::PROTO_DSTOPT)) begin
      r.ph = phsc_pkg::PH_OPT; r.len = 16'd8; r.ext = e + 4'd1;
    end else if (e < 4'(phsc_pkg::MAX_EXT_HEADERS) && p == phsc_pkg::PROTO_AH) begin
      r.ph = phsc_pkg::PH_AH; r.len = 16'd12; r.ext = e + 4'd1;
    end else if (e < 4'(phsc_pkg::MAX_EXT_HEADERS) && p == phsc_pkg::PROTO_FRAG) begin
      r.ph = phsc_pkg::PH_FRAG; r.len = 16'd8; r.ext = e + 4'd1;
    end else if (e < 4'(phsc_pkg::MAX_EXT_HEADERS) && p == phsc_pkg::PROTO_ESP) begin
      r.ph = phsc_pkg::PH_DONE;
    end else if (p == phsc_pkg::PROTO_TCP) begin
      r.ph = phsc_pkg::PH_TCP; r.len = 16'd20;
    end
    return r;
  endfunction

  function automatic logic [phsc_pkg::NUM_EVENTS-1:0] proto_bump(input logic [7:0] p);
    logic [phsc_pkg::NUM_EVENTS-1:0] m;
    m = '0;
    case (p)
      phsc_pkg::PROTO_TCP:   m[phsc_pkg::C_TCP]   = 1'b1;
      phsc_pkg::PROTO_UDP:   m[phsc_pkg::C_UDP]   = 1'b1;
      phsc_pkg::PROTO_ICMP:  m[phsc_pkg::C_ICMP]  = 1'b1;
      phsc_pkg::PROTO_ICMP6: m[phsc_pkg::C_ICMP6] = 1'b1;
      default:               m = '0;
    endcase
    return m;
  endfunction

  assign shifted = {fsh_r[7:0], data_byte};
  assign pos_p1  = {1'b0, pos_r} + 17'd1;
  assign ihl4    = (data_byte[3:0] < 4'd5) ? 6'd20 : {data_byte[3:0], 2'b00};

  // Next-state logic of the parser.
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hend_nxt   = hend_r;
    nproto_nxt = nproto_r;
    ext_nxt    = ext_r;
    fsh_nxt    = fsh_r;
    bump       = '0;
    port_inc   = 1'b0;
    ent        = 1'b0;
    adv_pos    = 1'b1;
    ent_h      = '{ph: phsc_pkg::PH_DONE, len: 16'd0, ext: ext_r};
    hend_eff   = hend_r;

    if (phase_r == phsc_pkg::PH_ETH && pos_r == 16'd0) bump[phsc_pkg::C_PKT] = 1'b1;
    bump[phsc_pkg::C_BYTES] = 1'b1;

    unique case (phase_r)
      phsc_pkg::PH_ETH: begin
        if (pos_r >= 16'd12) fsh_nxt = shifted;
        if (pos_r >= 16'd13) begin
          ent = 1'b1;
          if (shifted == phsc_pkg::ETH_IP4) begin
            bump[phsc_pkg::C_IP] = 1'b1;
            ent_h.ph = phsc_pkg::PH_IP4; ent_h.len = 16'd20;
          end else if (shifted == phsc_pkg::ETH_IP6) begin
            bump[phsc_pkg::C_IP6] = 1'b1;
            ent_h.ph = phsc_pkg::PH_IP6; ent_h.len = 16'd40;
          end else if (shifted == phsc_pkg::ETH_ARP) begin
            bump[phsc_pkg::C_ARP] = 1'b1;
          end
        end
      end
      phsc_pkg::PH_IP4: begin
        if (pos_r == 16'd0) begin
          hend_eff = {10'd0, ihl4};
          hend_nxt = hend_eff;
        end
        if (pos_r == 16'd6 || pos_r == 16'd7) fsh_nxt = shifted;
        if (pos_r == 16'd9) nproto_nxt = data_byte;
        if (pos_p1 >= {1'b0, hend_eff}) begin
          ent  = 1'b1;
          bump = bump | proto_bump(nproto_nxt);
          if (proto_bump(nproto_nxt) != '0 &&
              (fsh_nxt & (phsc_pkg::FRAG_MF_MASK | phsc_pkg::FRAG_OFF_MASK)) != 16'd0)
            bump[phsc_pkg::C_FRAG] = 1'b1;
          if (nproto_nxt == phsc_pkg::PROTO_TCP) begin
            ent_h.ph = phsc_pkg::PH_TCP; ent_h.len = 16'd20;
          end
        end
      end
      phsc_pkg::PH_IP6: begin
        if (pos_r == 16'd6) nproto_nxt = data_byte;
        if (pos_r >= 16'd39) begin
          ent   = 1'b1;
          bump  = bump | proto_bump(nproto_nxt);
          ent_h = after_ip(nproto_nxt, 4'd0);
        end
      end
      phsc_pkg::PH_AH, phsc_pkg::PH_OPT: begin
        if (pos_r == 16'd0) nproto_nxt = data_byte;
        if (pos_r == 16'd1) begin
          if (phase_r == phsc_pkg::PH_AH)
            hend_eff = {4'd0, ({2'b00, (data_byte == 8'd0) ? 8'd1 : data_byte} + 10'd2), 2'b00};
          else
            hend_eff = {4'd0, ({1'b0, data_byte} + 9'd1), 3'b000};
          hend_nxt = hend_eff;
        end
        if (pos_r >= 16'd1 && pos_p1 >= {1'b0, hend_eff}) begin
          ent   = 1'b1;
          ent_h = after_ip(nproto_nxt, ext_r);
        end
      end
      phsc_pkg::PH_FRAG: begin
        if (pos_r == 16'd0) nproto_nxt = data_byte;
        if (pos_r == 16'd2 || pos_r == 16'd3) fsh_nxt = shifted;
        if (pos_r >= 16'd7) begin
          ent = 1'b1;
          if ((fsh_nxt & phsc_pkg::FRAG6_MASK) != 16'd0) bump[phsc_pkg::C_FRAG] = 1'b1;
          ent_h = after_ip(nproto_nxt, ext_r);
        end
      end
      phsc_pkg::PH_TCP: begin
        if (pos_r == 16'd2 || pos_r == 16'd3) fsh_nxt = shifted;
        if (pos_r == 16'd13) nproto_nxt = data_byte;
        if (pos_r >= 16'd19) begin
          ent = 1'b1;
          bump[phsc_pkg::C_ACK] = nproto_nxt[4];
          bump[phsc_pkg::C_SYN] = nproto_nxt[1];
          bump[phsc_pkg::C_FIN] = nproto_nxt[0];
          bump[phsc_pkg::C_RST] = nproto_nxt[2];
          port_inc = 1'b1;
        end
      end
      default: begin
        phase_nxt = phsc_pkg::PH_DONE;
        adv_pos   = 1'b0;
      end
    endcase

    if (ent) begin
      phase_nxt = ent_h.ph;
      pos_nxt   = 16'd0;
      hend_nxt  = ent_h.len;
      fsh_nxt   = 16'd0;
      ext_nxt   = ent_h.ext;
    end else if (adv_pos && pos_r != 16'hFFFF) begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  // Output logic: compose the operation for the counter engine.
  always_comb begin
    op          = '0;
    push        = 1'b0;
    op.index    = read_index;
    unique case (command)
      phsc_pkg::CMD_BYTE: begin
        push        = accept;
        op.kind     = phsc_pkg::OP_BYTE;
        op.bump     = bump;
        op.port_inc = port_inc;
        op.index    = fsh_r;
        op.emit     = last_byte;
        op.verdict  = (phase_nxt != phsc_pkg::PH_DONE);
      end
      phsc_pkg::CMD_RD_GEN: begin
        push    = accept;
        op.kind = phsc_pkg::OP_RD_GEN;
        op.emit = 1'b1;
      end
      phsc_pkg::CMD_RD_PORT: begin
        push    = accept;
        op.kind = phsc_pkg::OP_RD_PORT;
        op.emit = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= phsc_pkg::PH_ETH;
      pos_r    <= '0;
      hend_r   <= '0;
      nproto_r <= '0;
      ext_r    <= '0;
      fsh_r    <= '0;
    end else if (accept && command == phsc_pkg::CMD_BYTE) begin
      if (last_byte) begin
        phase_r  <= phsc_pkg::PH_ETH;
        pos_r    <= '0;
        hend_r   <= '0;
        nproto_r <= '0;
        ext_r    <= '0;
        fsh_r    <= '0;
      end else begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        hend_r   <= hend_nxt;
        nproto_r <= nproto_nxt;
        ext_r    <= ext_nxt;
        fsh_r    <= fsh_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/phsc_fifo.sv
// Short operation queue between the parser and the counter engine.
// Depends on phsc_pkg.
`default_nettype none
module phsc_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  phsc_pkg::op_t push_op,
  input  wire logic     pop,
  output phsc_pkg::op_t head,
  output logic          empty,
  output logic          full
);

  phsc_pkg::op_t               mem_r [phsc_pkg::FIFO_DEPTH];
  logic [phsc_pkg::FIFO_AW-1:0] wr_r, rd_r;
  logic [phsc_pkg::FIFO_AW:0]   cnt_r;

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (phsc_pkg::FIFO_AW+1)'(phsc_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (phsc_pkg::FIFO_AW+1)'(push) - (phsc_pkg::FIFO_AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/phsc_back.sv
// Counter engine: general counters, the per-port counter memory and the result register.
// Depends on phsc_pkg.
`default_nettype none
module phsc_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  phsc_pkg::op_t    head,
  input  wire logic        empty,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic             out_verdict,
  output logic [63:0]      out_count
);

  logic [63:0] gen_r [phsc_pkg::COUNTER_SLOTS];
  logic [63:0] port_mem [phsc_pkg::PORT_ENTRIES];
  logic [63:0] rd_data_r;

  logic                        clr_busy_r;
  logic [phsc_pkg::PORT_AW-1:0] clr_addr_r;

  logic                        b_valid_r, b_emit_r, b_verdict_r, b_inc_r;
  phsc_pkg::op_kind_t          b_kind_r;
  logic [phsc_pkg::PORT_AW-1:0] b_addr_r;
  logic [63:0]                 b_gen_r;

  logic                        fwd_valid_r;
  logic [phsc_pkg::PORT_AW-1:0] fwd_addr_r;
  logic [63:0]                 fwd_data_r;

  logic                        out_valid_r, out_kind_r, out_verdict_r;
  logic [63:0]                 out_count_r;

  logic                        adv, mem_we;
  logic [phsc_pkg::PORT_AW-1:0] mem_waddr;
  logic [63:0]                 mem_wdata, port_val, gen_rd;
  logic [phsc_pkg::COUNTER_SLOTS-1:0] bump_ext;

  assign adv      = !out_valid_r || out_ready;
  assign pop      = adv && !empty && !clr_busy_r;
  assign clearing = clr_busy_r;
  assign bump_ext = phsc_pkg::COUNTER_SLOTS'(head.bump);

  assign gen_rd = ({16'd0, head.index} < 32'(phsc_pkg::COUNTER_SLOTS)) ?
                  gen_r[head.index[phsc_pkg::GEN_AW-1:0]] : 64'd0;

  // A write issued in the same cycle as this entry's read is not in rd_data_r.
  assign port_val  = (fwd_valid_r && fwd_addr_r == b_addr_r) ? fwd_data_r : rd_data_r;
  assign mem_we    = clr_busy_r || (adv && b_valid_r && b_inc_r);
  assign mem_waddr = clr_busy_r ? clr_addr_r : b_addr_r;
  assign mem_wdata = clr_busy_r ? 64'd0 : port_val + 64'd1;

  always_ff @(posedge clk) begin
    if (mem_we) port_mem[mem_waddr] <= mem_wdata;
    if (pop) rd_data_r <= port_mem[head.index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < phsc_pkg::COUNTER_SLOTS; i++) gen_r[i] <= 64'd0;
    end else if (pop && head.kind == phsc_pkg::OP_BYTE) begin
      for (int i = 0; i < phsc_pkg::COUNTER_SLOTS; i++)
        if (bump_ext[i]) gen_r[i] <= gen_r[i] + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        b_valid_r   <= pop;
        out_valid_r <= b_valid_r && b_emit_r;
      end
      if (adv && b_valid_r && b_inc_r) fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_kind_r    <= head.kind;
      b_emit_r    <= head.emit;
      b_verdict_r <= head.verdict;
      b_inc_r     <= head.port_inc;
      b_addr_r    <= head.index;
      b_gen_r     <= gen_rd;
    end
    if (adv && b_valid_r && b_inc_r) begin
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= mem_wdata;
    end
    if (adv && b_valid_r) begin
      case (b_kind_r)
        phsc_pkg::OP_RD_GEN: begin
          out_kind_r    <= phsc_pkg::KIND_COUNT;
          out_verdict_r <= 1'b0;
          out_count_r   <= b_gen_r;
        end
        phsc_pkg::OP_RD_PORT: begin
          out_kind_r    <= phsc_pkg::KIND_COUNT;
          out_verdict_r <= 1'b0;
          out_count_r   <= port_val;
        end
        default: begin
          out_kind_r    <= phsc_pkg::KIND_VERDICT;
          out_verdict_r <= b_verdict_r;
          out_count_r   <= 64'd0;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_verdict = out_verdict_r;
  assign out_count   = out_count_r;

endmodule
`default_nettype wire

>>> rtl/packet_header_stats_counter_core.sv
// Top level of the packet header statistics counter: parser, queue and counter engine.
// Depends on phsc_pkg, phsc_front, phsc_fifo and phsc_back.
//
// Usage. Items enter on the in_ stream. in_tuser is the command: a frame byte, a read
// of a general counter, or a read of a per-destination-port counter. Frame bytes come
// in wire order in in_tdata[7:0] with in_tlast on the final byte of the frame; reads
// carry the slot or port in in_tdata[23:8]. Each frame's final byte yields one verdict
// item (pass, or aborted when the frame ended inside a needed header), each read yields
// one item with the counter value, and other bytes yield nothing.
// Throughput is one item per cycle while the queue is not full and no sweep runs. The
// parser classifies a byte in the cycle it is accepted; the counter engine then takes
// it from a four-entry queue, reads the port memory into a registered stage and then
// registers the result, so out_tvalid and the output fields come from that register.
// After reset the port counter memory is swept to zero, one entry per cycle, over all
// 65536 entries; in_tready stays low until then. General counters clear at once.
// When the receiver holds out_tready low, the engine stops and the queue fills; in_tready
// falls only once the queue is full, so a short stall does not reach the sender.
`default_nettype none
module packet_header_stats_counter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_byte [7:0], read_index [23:8]
  input  wire logic [1:0]  in_tuser,   // command [1:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // verdict [0], count_value [64:1], zero [71:65]
  output logic             out_tuser   // result_kind [0]
);

  logic          accept, push, pop, empty, full, clearing;
  logic          out_verdict;
  logic [63:0]   out_count;
  phsc_pkg::op_t push_op, head;

  // The front stalls only when the queue is full or the port memory is being swept.
  assign in_tready = !full && !clearing;
  assign accept    = in_tvalid && in_tready;

  phsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_tuser),
    .data_byte  (in_tdata[7:0]),
    .last_byte  (in_tlast),
    .read_index (in_tdata[23:8]),
    .push       (push),
    .op         (push_op)
  );

  phsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  phsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_verdict (out_verdict),
    .out_count   (out_count)
  );

  assign out_tdata = {7'd0, out_count, out_verdict};

endmodule
`default_nettype wire
